// ----- hdl/csma_pkg.sv -----
// Shared types, codes and helper functions for the CSMA/CA sender state machine.
package csma_pkg;

  // Sender states, same encoding as the state result field
  typedef enum logic [2:0] {
    ST_DIFS  = 3'd0,
    ST_CONT  = 3'd1,
    ST_RTS   = 3'd2,
    ST_SEND  = 3'd3,
    ST_SIFS  = 3'd4,
    ST_WACK  = 3'd5,
    ST_DEFER = 3'd6
  } csma_state_t;

  // Input item modes
  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_ENQUEUE = 3'd1,
    MODE_BUSY    = 3'd2,
    MODE_ACK     = 3'd3,
    MODE_CTS     = 3'd4,
    MODE_FORCE   = 3'd5,
    MODE_SRESET  = 3'd6,
    MODE_NOP     = 3'd7
  } csma_mode_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DIFS_SLOTS  = 3'd0,
    CFG_SIFS_SLOTS  = 3'd1,
    CFG_DATA_SLOTS  = 3'd2,
    CFG_ACK_SLOTS   = 3'd3,
    CFG_CW_MIN_LOG2 = 3'd4,
    CFG_CW_MAX_LOG2 = 3'd5,
    CFG_VCS_ENABLED = 3'd6,
    CFG_UNUSED      = 3'd7
  } csma_cfg_idx_t;

  // Register reset values
  localparam logic [7:0] DIFS_SLOTS_RST  = 8'd3;
  localparam logic [7:0] SIFS_SLOTS_RST  = 8'd1;
  localparam logic [7:0] DATA_SLOTS_RST  = 8'd10;
  localparam logic [7:0] ACK_SLOTS_RST   = 8'd2;
  localparam logic [3:0] CW_MIN_RST      = 4'd2;
  localparam logic [3:0] CW_MAX_RST      = 4'd10;

  // Widest usable backoff window (log2)
  localparam logic [3:0] WIN_LOG2_CAP    = 4'd10;
  localparam logic [8:0] RTS_DEFER_DIFS  = 9'd5;
  localparam logic [8:0] RTS_DEFER_CONT  = 9'd6;

  localparam int PEND_W    = 16;
  localparam int BACKOFF_W = 10;

  // Slot length minus one, zero treated as one slot
  function automatic logic [7:0] less_one(input logic [7:0] v);
    less_one = (v == 8'd0) ? 8'd0 : v - 8'd1;
  endfunction

  // Random draw masked to the current window
  function automatic logic [BACKOFF_W-1:0] draw_backoff(input logic [BACKOFF_W-1:0] rnd,
                                                        input logic [3:0] win);
    logic [3:0]         w;
    logic [BACKOFF_W:0] m;
    w = (win > WIN_LOG2_CAP) ? WIN_LOG2_CAP : win;
    m = ({{BACKOFF_W{1'b0}}, 1'b1} << w) - {{BACKOFF_W{1'b0}}, 1'b1};
    draw_backoff = rnd & m[BACKOFF_W-1:0];
  endfunction

  // Window doubling, capped at the maximum
  function automatic logic [3:0] widen_window(input logic [3:0] win, input logic [3:0] wmax);
    logic [4:0] w;
    w = {1'b0, win} + 5'd1;
    if (w > {1'b0, wmax}) begin
      w = {1'b0, wmax};
    end
    widen_window = w[3:0];
  endfunction

endpackage

// ----- hdl/csma_ca_sender_fsm.sv -----
// Top level of the CSMA/CA sender state machine with binary exponential backoff.
//
// Input channel (in_*): one item per transfer; mode selects a slot tick, a frame
// enqueue, a busy/ack/cts flag write, a forced state or a soft reset.
// Result channel (out_*): exactly one result per input item, showing state,
// ready_for_clearance, frame_sent, frames_pending and backoff_left after the item.
// Configuration (cfg_*): index/data writes, always ready; write only while idle.
// A slot or window register write takes effect at the next reload of the matching counter or window.
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one item per cycle while in_stall is low; all state updates are a
// single level of counter decrement/compare logic between the state registers
// and the result register.
// in_stall is raised only while a result is held and out_stall is high, so the
// result register never drops or repeats a result.
// Reset (rst_n low, synchronous): configuration returns to defaults, state is
// DIFS with counters reloaded, backoff zero, no result pending.
module csma_ca_sender_fsm (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_mode,
  input  logic                          in_flag_value,
  input  logic [2:0]                    in_new_state,
  input  logic [15:0]                   in_random_word,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_state,
  output logic                          out_ready_for_clearance,
  output logic                          out_frame_sent,
  output logic [csma_pkg::PEND_W-1:0]   out_frames_pending,
  output logic [csma_pkg::BACKOFF_W-1:0] out_backoff_left,
  // configuration port
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [7:0]                    cfg_data
);
  import csma_pkg::*;

  // configuration registers
  logic [7:0] difs_slots_r, sifs_slots_r, data_slots_r, ack_slots_r;
  logic [3:0] cw_min_r, cw_max_r;
  logic       vcs_en_r;

  // machine state
  csma_state_t           state_r, state_nxt;
  logic [7:0]            difs_cnt_r, difs_cnt_nxt;
  logic [7:0]            sifs_cnt_r, sifs_cnt_nxt;
  logic [8:0]            data_cnt_r, data_cnt_nxt;
  logic [7:0]            ack_cnt_r, ack_cnt_nxt;
  logic [8:0]            rts_cnt_r, rts_cnt_nxt;
  logic [BACKOFF_W-1:0]  backoff_r, backoff_nxt;
  logic [3:0]            win_r, win_nxt;
  logic [PEND_W-1:0]     pend_r, pend_nxt;
  logic                  busy_r, busy_nxt;
  logic                  ack_r, ack_nxt;
  logic                  cts_r, cts_nxt;
  logic                  rdy_r, rdy_nxt;
  logic                  sent_r, sent_nxt;

  // result register
  logic                  out_valid_r;
  logic [2:0]            out_state_r;
  logic                  out_rdy_r, out_sent_r;
  logic [PEND_W-1:0]     out_pend_r;
  logic [BACKOFF_W-1:0]  out_backoff_r;

  logic                  in_xfer;
  csma_mode_t            mode;
  logic [7:0]            am1;
  logic [3:0]            win_tmp;
  logic [BACKOFF_W-1:0]  rnd;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_xfer   = in_valid & ~in_stall;
  assign mode      = csma_mode_t'(in_mode);
  assign am1       = less_one(ack_slots_r);
  assign rnd       = in_random_word[BACKOFF_W-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      difs_slots_r <= DIFS_SLOTS_RST;
      sifs_slots_r <= SIFS_SLOTS_RST;
      data_slots_r <= DATA_SLOTS_RST;
      ack_slots_r  <= ACK_SLOTS_RST;
      cw_min_r     <= CW_MIN_RST;
      cw_max_r     <= CW_MAX_RST;
      vcs_en_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (csma_cfg_idx_t'(cfg_index))
        CFG_DIFS_SLOTS:  difs_slots_r <= cfg_data;
        CFG_SIFS_SLOTS:  sifs_slots_r <= cfg_data;
        CFG_DATA_SLOTS:  data_slots_r <= cfg_data;
        CFG_ACK_SLOTS:   ack_slots_r  <= cfg_data;
        CFG_CW_MIN_LOG2: cw_min_r     <= cfg_data[3:0];
        CFG_CW_MAX_LOG2: cw_max_r     <= cfg_data[3:0];
        CFG_VCS_ENABLED: vcs_en_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (mode)
      MODE_TICK: begin
        unique case (state_r)
          ST_CONT: begin
            if (busy_r) begin
              state_nxt = ST_DEFER;
            end else if (backoff_r == '0) begin
              state_nxt = vcs_en_r ? ST_RTS : ST_SEND;
            end
          end
          ST_SEND: if (data_cnt_r == 9'd0) state_nxt = ST_SIFS;
          ST_WACK: if (ack_cnt_r == 8'd0) state_nxt = ST_DIFS;
          ST_RTS:  if (rts_cnt_r == 9'd0) state_nxt = cts_r ? ST_SEND : ST_DIFS;
          ST_SIFS: if (sifs_cnt_r == 8'd0) state_nxt = ST_WACK;
          ST_DIFS: begin
            if (busy_r) begin
              state_nxt = ST_DEFER;
            end else if (difs_cnt_r == 8'd0 && pend_r != '0) begin
              state_nxt = ST_CONT;
            end
          end
          default: ;
        endcase
      end
      MODE_FORCE: begin
        if (in_new_state <= 3'(ST_DEFER)) begin
          state_nxt = csma_state_t'(in_new_state);
        end
      end
      MODE_SRESET: state_nxt = ST_DIFS;
      default: ;
    endcase
  end

  // counters, window and flags
  always_comb begin
    difs_cnt_nxt = difs_cnt_r;
    sifs_cnt_nxt = sifs_cnt_r;
    data_cnt_nxt = data_cnt_r;
    ack_cnt_nxt  = ack_cnt_r;
    rts_cnt_nxt  = rts_cnt_r;
    backoff_nxt  = backoff_r;
    win_nxt      = win_r;
    pend_nxt     = pend_r;
    busy_nxt     = busy_r;
    ack_nxt      = ack_r;
    cts_nxt      = cts_r;
    rdy_nxt      = rdy_r;
    sent_nxt     = sent_r;
    win_tmp      = win_r;
    unique case (mode)
      MODE_TICK: begin
        unique case (state_r)
          ST_CONT: begin
            if (busy_r) begin
              if (vcs_en_r) rts_cnt_nxt = {1'b0, am1} + RTS_DEFER_CONT;
              data_cnt_nxt = {1'b0, less_one(data_slots_r)} + 9'd1;
            end
            if (backoff_r == '0 && !busy_r) begin
              if (vcs_en_r) rts_cnt_nxt = ({1'b0, am1} + 9'd1) << 1;
            end else if (backoff_r != '0) begin
              backoff_nxt = backoff_r - BACKOFF_W'(1);
            end
          end
          ST_SEND: begin
            if (data_cnt_r == 9'd0) begin
              data_cnt_nxt = {1'b0, less_one(data_slots_r)};
            end else begin
              data_cnt_nxt = data_cnt_r - 9'd1;
            end
          end
          ST_WACK: begin
            if (ack_cnt_r == 8'd0) begin
              if (ack_r) begin
                ack_nxt  = 1'b0;
                sent_nxt = 1'b1;
                if (pend_r != '0) pend_nxt = pend_r - PEND_W'(1);
                win_tmp  = cw_min_r;
              end else begin
                win_tmp  = widen_window(win_r, cw_max_r);
              end
              win_nxt     = win_tmp;
              backoff_nxt = draw_backoff(rnd, win_tmp);
              ack_cnt_nxt = am1;
            end else begin
              ack_cnt_nxt = ack_cnt_r - 8'd1;
            end
          end
          ST_RTS: begin
            if (rts_cnt_r == 9'd1) rdy_nxt = 1'b1;
            if (rts_cnt_r == 9'd0) begin
              rdy_nxt = 1'b0;
              if (cts_r) begin
                cts_nxt = 1'b0;
              end else begin
                win_tmp     = widen_window(win_r, cw_max_r);
                win_nxt     = win_tmp;
                backoff_nxt = draw_backoff(rnd, win_tmp);
              end
            end else begin
              rts_cnt_nxt = rts_cnt_r - 9'd1;
            end
          end
          ST_SIFS: begin
            if (sifs_cnt_r == 8'd0) begin
              sifs_cnt_nxt = less_one(sifs_slots_r);
            end else begin
              sifs_cnt_nxt = sifs_cnt_r - 8'd1;
            end
          end
          ST_DIFS: begin
            sent_nxt = 1'b0;
            if (difs_cnt_r == 8'd0) begin
              difs_cnt_nxt = less_one(difs_slots_r);
            end else begin
              difs_cnt_nxt = difs_cnt_r - 8'd1;
            end
            if (busy_r) begin
              data_cnt_nxt = {1'b0, less_one(data_slots_r)} + 9'd1;
              busy_nxt     = 1'b0;
              rts_cnt_nxt  = vcs_en_r ? ({1'b0, am1} + RTS_DEFER_DIFS) : 9'd0;
            end
          end
          ST_DEFER: busy_nxt = 1'b0;
          default: ;
        endcase
      end
      MODE_ENQUEUE: begin
        if (pend_r != {PEND_W{1'b1}}) pend_nxt = pend_r + PEND_W'(1);
      end
      MODE_BUSY: busy_nxt = in_flag_value;
      MODE_ACK:  ack_nxt  = in_flag_value;
      MODE_CTS:  cts_nxt  = in_flag_value;
      MODE_SRESET: begin
        pend_nxt     = '0;
        difs_cnt_nxt = less_one(difs_slots_r);
        sifs_cnt_nxt = less_one(sifs_slots_r);
        data_cnt_nxt = {1'b0, less_one(data_slots_r)};
        ack_cnt_nxt  = am1;
        rts_cnt_nxt  = {1'b0, am1};
        win_nxt      = cw_min_r;
        busy_nxt     = 1'b0;
        rdy_nxt      = 1'b0;
        sent_nxt     = 1'b0;
        backoff_nxt  = draw_backoff(rnd, cw_min_r);
      end
      default: ;
    endcase
  end

  // machine state registers, updated on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_DIFS;
      difs_cnt_r <= less_one(DIFS_SLOTS_RST);
      sifs_cnt_r <= less_one(SIFS_SLOTS_RST);
      data_cnt_r <= {1'b0, less_one(DATA_SLOTS_RST)};
      ack_cnt_r  <= less_one(ACK_SLOTS_RST);
      rts_cnt_r  <= {1'b0, less_one(ACK_SLOTS_RST)};
      backoff_r  <= '0;
      win_r      <= CW_MIN_RST;
      pend_r     <= '0;
      busy_r     <= 1'b0;
      ack_r      <= 1'b0;
      cts_r      <= 1'b0;
      rdy_r      <= 1'b0;
      sent_r     <= 1'b0;
    end else if (in_xfer) begin
      state_r    <= state_nxt;
      difs_cnt_r <= difs_cnt_nxt;
      sifs_cnt_r <= sifs_cnt_nxt;
      data_cnt_r <= data_cnt_nxt;
      ack_cnt_r  <= ack_cnt_nxt;
      rts_cnt_r  <= rts_cnt_nxt;
      backoff_r  <= backoff_nxt;
      win_r      <= win_nxt;
      pend_r     <= pend_nxt;
      busy_r     <= busy_nxt;
      ack_r      <= ack_nxt;
      cts_r      <= cts_nxt;
      rdy_r      <= rdy_nxt;
      sent_r     <= sent_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_state_r   <= 3'(state_nxt);
      out_rdy_r     <= rdy_nxt;
      out_sent_r    <= sent_nxt;
      out_pend_r    <= pend_nxt;
      out_backoff_r <= backoff_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_state               = out_state_r;
  assign out_ready_for_clearance = out_rdy_r;
  assign out_frame_sent          = out_sent_r;
  assign out_frames_pending      = out_pend_r;
  assign out_backoff_left        = out_backoff_r;

endmodule
